// File: rtl/core/heat_stencil_row_sweep_core_assert.svh
// Assertion macros shared by the heat stencil core modules.
`ifndef HEAT_STENCIL_ROW_SWEEP_CORE_ASSERT_SVH
`define HEAT_STENCIL_ROW_SWEEP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSRS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("heat stencil core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HSRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("heat stencil core: assertion failed");

`endif

// File: rtl/core/hsrs_pkg.sv
// Shared types and constants of the heat stencil row sweep core.
package hsrs_pkg;

    // Default parameter values.
    localparam int MAX_ROW_LENGTH_DEFAULT = 1024;
    localparam int FRACTION_BITS_DEFAULT  = 16;

    // Field widths fixed by the interface.
    localparam int DATA_W     = 32;
    localparam int ROW_LEN_W  = 11;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // A Laplacian term W - 2C + E of 32-bit operands needs 34 bits.
    localparam int LAP_W = DATA_W + 2;

    // Row length limits and reset value.
    localparam int MIN_ROW_LENGTH   = 3;
    localparam int ROW_LENGTH_RESET = 64;

    // Result queue depth: covers the arithmetic pipeline plus slack.
    localparam int OUT_FIFO_DEPTH = 8;

    // Opcode carried on tuser of the input stream.
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_LENGTH = 2'd0,
        CFG_COEF_X     = 2'd1,
        CFG_COEF_Y     = 2'd2
    } cfg_index_t;

    // One cell handed to the arithmetic pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] center;
        logic [LAP_W-1:0]  lap_x;
        logic [LAP_W-1:0]  lap_y;
        logic              edge_col;
        logic              end_of_row;
        logic              end_of_grid;
    } stencil_op_t;

    // One finished result.
    typedef struct packed {
        logic [DATA_W-1:0] new_temperature;
        logic              end_of_row;
        logic              end_of_grid;
    } cell_result_t;

endpackage

// File: rtl/core/hsrs_arith.sv
// Three-stage arithmetic pipeline: coefficient products, rounded sum, saturation.
module hsrs_arith #(
    parameter int FRACTION_BITS = hsrs_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  hsrs_pkg::stencil_op_t         in_op,
    input  logic [hsrs_pkg::COEF_W-1:0]   coef_x,
    input  logic [hsrs_pkg::COEF_W-1:0]   coef_y,
    output logic                          out_valid,
    output hsrs_pkg::cell_result_t        out_result,
    output logic [1:0]                    inflight
);

    localparam int DATA_W = hsrs_pkg::DATA_W;
    localparam int PROD_W = hsrs_pkg::LAP_W + hsrs_pkg::COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

    // Stage 1: operands as delivered by the sequencer.
    logic                  v1_reg;
    hsrs_pkg::stencil_op_t op1_reg;

    // Stage 2: the two coefficient products.
    logic                    v2_reg;
    logic [DATA_W-1:0]       c2_reg;
    logic signed [PROD_W-1:0] px2_reg;
    logic signed [PROD_W-1:0] py2_reg;
    logic                    pass2_reg;
    logic                    eor2_reg;
    logic                    eog2_reg;

    // Stage 3: the sum with the rounding offset already added.
    logic                    v3_reg;
    logic [DATA_W-1:0]       c3_reg;
    logic signed [SUM_W-1:0] sum3_reg;
    logic                    pass3_reg;
    logic                    eor3_reg;
    logic                    eog3_reg;

    logic signed [SUM_W-1:0] incr;
    logic signed [SUM_W-1:0] total;
    logic                    fits;
    logic [DATA_W-1:0]       sat_value;

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge aclk) begin
        op1_reg   <= in_op;
        c2_reg    <= op1_reg.center;
        px2_reg   <= $signed(op1_reg.lap_x) * $signed({1'b0, coef_x});
        py2_reg   <= $signed(op1_reg.lap_y) * $signed({1'b0, coef_y});
        pass2_reg <= op1_reg.edge_col;
        eor2_reg  <= op1_reg.end_of_row;
        eog2_reg  <= op1_reg.end_of_grid;
        c3_reg    <= c2_reg;
        sum3_reg  <= SUM_W'(px2_reg) + SUM_W'(py2_reg) + ROUND_HALF;
        pass3_reg <= pass2_reg;
        eor3_reg  <= eor2_reg;
        eog3_reg  <= eog2_reg;
    end

    // Floor shift back to the temperature grid, add the centre and saturate.
    always_comb begin
        incr  = sum3_reg >>> FRACTION_BITS;
        total = SUM_W'($signed(c3_reg)) + incr;
        fits  = (&total[SUM_W-1:DATA_W-1]) || !(|total[SUM_W-1:DATA_W-1]);
        if (fits) begin
            sat_value = total[DATA_W-1:0];
        end else if (total[SUM_W-1]) begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Edge columns pass the centre through unchanged.
    assign out_valid                  = v3_reg;
    assign out_result.new_temperature = pass3_reg ? c3_reg : sat_value;
    assign out_result.end_of_row      = eor3_reg;
    assign out_result.end_of_grid     = eog3_reg;
    assign inflight = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);

endmodule

// File: rtl/core/hsrs_fifo.sv
// Result queue that drives the master stream.
`include "heat_stencil_row_sweep_core_assert.svh"

module hsrs_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_valid,
    input  hsrs_pkg::cell_result_t              wr_data,
    output logic [$clog2(hsrs_pkg::OUT_FIFO_DEPTH+1)-1:0] count,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hsrs_pkg::DATA_W-1:0]         m_tdata,  // [31:0] new_temperature
    output logic                                m_tlast,
    output logic                                m_tuser   // [0] end_of_grid
);

    localparam int DEPTH = hsrs_pkg::OUT_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsrs_pkg::cell_result_t fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    hsrs_pkg::cell_result_t head;

    assign pop = m_tvalid && m_tready;

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (wr_valid && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!wr_valid && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointer and occupancy registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            fifo_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.new_temperature;
    assign m_tlast  = head.end_of_row;
    assign m_tuser  = head.end_of_grid;

    `HSRS_ASSERT_NOW(a_no_overflow, wr_valid, (count_reg < CNT_W'(DEPTH)) || pop)
    `HSRS_ASSERT_NOW(a_empty_pointers, count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `HSRS_ASSERT_NEXT(a_push_counts, wr_valid && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// File: rtl/core/heat_stencil_row_sweep_core.sv
// Top level of the heat stencil row sweep core: line stores, sequencing and config.
//
// One explicit time step of 2-D heat diffusion over a grid streamed in raster order.
// Slave stream: tdata carries a signed Q16.16 temperature, tuser the opcode (sample or
// flush). Each accepted sample of row r produces the updated cell of row r-1 in the
// same column on the master stream; the first row produces nothing. After the last
// row, one flush transaction per cell emits the final row, with end_of_grid on its
// last cell, and the block starts over for the next grid.
// Master stream: tdata is the new temperature, tlast marks the end of a row and tuser
// the end of the grid.
// Throughput is one transaction per cycle as long as the slave side keeps accepting. Both
// line stores are read ahead, into registers, at the column the next transaction will
// use, so the store access completes within the acceptance cycle; the three-stage
// multiply, round and saturate pipeline follows and feeds the queue. The config channel
// is always ready; the user must write it only while idle, as the block does not check.
// Reset clears sequencing, queue and registers; the line stores need no clearing.
// When the receiver stalls, results collect in an eight-entry queue and the slave
// side stops accepting only once queue and pipeline together hold its capacity.
`include "heat_stencil_row_sweep_core_assert.svh"

module heat_stencil_row_sweep_core #(
    parameter int MAX_ROW_LENGTH = hsrs_pkg::MAX_ROW_LENGTH_DEFAULT,
    parameter int FRACTION_BITS  = hsrs_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hsrs_pkg::DATA_W-1:0]       s_tdata,   // [31:0] temperature
    input  logic                              s_tuser,   // [0] opcode
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hsrs_pkg::DATA_W-1:0]       m_tdata,   // [31:0] new_temperature
    output logic                              m_tlast,   // end_of_row
    output logic                              m_tuser,   // [0] end_of_grid
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DATA_W = hsrs_pkg::DATA_W;
    localparam int LAP_W  = hsrs_pkg::LAP_W;
    localparam int COL_W  = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W  = (COL_W + 1 > hsrs_pkg::ROW_LEN_W) ? COL_W + 1 : hsrs_pkg::ROW_LEN_W;
    localparam int DEPTH  = hsrs_pkg::OUT_FIFO_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CRD_W  = CNT_W + 1;

    // Configuration registers.
    logic [hsrs_pkg::ROW_LEN_W-1:0] row_length_reg;
    logic [hsrs_pkg::COEF_W-1:0]    coef_x_reg;
    logic [hsrs_pkg::COEF_W-1:0]    coef_y_reg;

    // Sequencing state.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             above_valid_reg;
    logic             above_valid_next;
    logic             flushing_reg;
    logic             flushing_next;
    logic [DATA_W-1:0] west_reg;

    // Line stores and their registered read data.
    logic [DATA_W-1:0] above_mem [MAX_ROW_LENGTH];
    logic [DATA_W-1:0] mid_mem   [MAX_ROW_LENGTH];
    logic [DATA_W-1:0] above_q_reg;
    logic [DATA_W-1:0] mid_c_q_reg;
    logic [DATA_W-1:0] mid_e_q_reg;
    logic [COL_W-1:0]  rd_addr;

    // Per-transaction decode.
    logic [LEN_W-1:0]  len_ext;
    logic [LEN_W-1:0]  len_eff;
    logic              is_last;
    logic              flush;
    logic              restart;
    logic              s_accept;
    logic              store_wr;
    logic              emit;
    logic [DATA_W-1:0] south;
    logic [DATA_W-1:0] north;
    logic [LAP_W-1:0]  lap_x;
    logic [LAP_W-1:0]  lap_y;
    hsrs_pkg::stencil_op_t op;

    // Pipeline and queue links.
    logic                   res_valid;
    hsrs_pkg::cell_result_t res_data;
    logic [1:0]             inflight;
    logic [CNT_W-1:0]       fifo_count;

    // Configuration writes; an unused index is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= hsrs_pkg::ROW_LEN_W'(hsrs_pkg::ROW_LENGTH_RESET);
            coef_x_reg     <= '0;
            coef_y_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hsrs_pkg::CFG_ROW_LENGTH: row_length_reg <= cfg_data[hsrs_pkg::ROW_LEN_W-1:0];
                hsrs_pkg::CFG_COEF_X:     coef_x_reg     <= cfg_data[hsrs_pkg::COEF_W-1:0];
                hsrs_pkg::CFG_COEF_Y:     coef_y_reg     <= cfg_data[hsrs_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the row length and find the last column of a row.
    always_comb begin
        len_ext = LEN_W'(row_length_reg);
        if (len_ext < LEN_W'(hsrs_pkg::MIN_ROW_LENGTH)) begin
            len_eff = LEN_W'(hsrs_pkg::MIN_ROW_LENGTH);
        end else if (len_ext > LEN_W'(MAX_ROW_LENGTH)) begin
            len_eff = LEN_W'(MAX_ROW_LENGTH);
        end else begin
            len_eff = len_ext;
        end
        is_last = LEN_W'(col_reg) >= (len_eff - LEN_W'(1));
    end

    // Accept while queue and pipeline together still have room for one more result.
    assign s_tready = (CRD_W'(fifo_count) + CRD_W'(inflight)) < CRD_W'(DEPTH);
    assign s_accept = s_tvalid && s_tready;
    assign flush    = (s_tuser == hsrs_pkg::OP_FLUSH) || flushing_reg;
    assign restart  = flush && first_row_reg;
    assign store_wr = s_accept && !restart;
    assign emit     = store_wr && !first_row_reg;

    // Next sequencing state after an accepted transaction.
    always_comb begin
        col_next         = col_reg;
        first_row_next   = first_row_reg;
        above_valid_next = above_valid_reg;
        flushing_next    = flushing_reg;
        if (s_accept) begin
            if (restart) begin
                col_next         = '0;
                first_row_next   = 1'b1;
                above_valid_next = 1'b0;
                flushing_next    = 1'b0;
            end else if (is_last) begin
                col_next = '0;
                if (flush) begin
                    first_row_next   = 1'b1;
                    above_valid_next = 1'b0;
                    flushing_next    = 1'b0;
                end else if (first_row_reg) begin
                    first_row_next = 1'b0;
                end else begin
                    above_valid_next = 1'b1;
                end
            end else begin
                col_next = col_reg + COL_W'(1);
                if (flush) begin
                    flushing_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            first_row_reg   <= 1'b1;
            above_valid_reg <= 1'b0;
            flushing_reg    <= 1'b0;
        end else begin
            col_reg         <= col_next;
            first_row_reg   <= first_row_next;
            above_valid_reg <= above_valid_next;
            flushing_reg    <= flushing_next;
        end
    end

    // The west neighbour is the centre of the previous transaction in the row.
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            west_reg <= mid_c_q_reg;
        end
    end

    // Line stores: read ahead, into registers, at the column of the next transaction.
    // The write always goes to the current column, never to an address being read.
    assign rd_addr = col_next;

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            above_mem[col_reg] <= mid_c_q_reg;
            mid_mem[col_reg]   <= south;
        end
        above_q_reg <= above_mem[rd_addr];
        mid_c_q_reg <= mid_mem[rd_addr];
        mid_e_q_reg <= mid_mem[rd_addr + COL_W'(1)];
    end

    // Neighbours and the two Laplacian terms.
    always_comb begin
        south = flush ? '0 : s_tdata;
        north = above_valid_reg ? above_q_reg : '0;
        lap_x = LAP_W'($signed(west_reg)) - (LAP_W'($signed(mid_c_q_reg)) << 1)
              + LAP_W'($signed(mid_e_q_reg));
        lap_y = LAP_W'($signed(north)) - (LAP_W'($signed(mid_c_q_reg)) << 1)
              + LAP_W'($signed(south));
        op.center      = mid_c_q_reg;
        op.lap_x       = lap_x;
        op.lap_y       = lap_y;
        op.edge_col    = (col_reg == '0) || is_last;
        op.end_of_row  = is_last;
        op.end_of_grid = flush && is_last;
    end

    hsrs_arith #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_arith (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (emit),
        .in_op      (op),
        .coef_x     (coef_x_reg),
        .coef_y     (coef_y_reg),
        .out_valid  (res_valid),
        .out_result (res_data),
        .inflight   (inflight)
    );

    hsrs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res_data),
        .count    (fifo_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `HSRS_ASSERT_NOW(a_first_row_no_above, first_row_reg, !above_valid_reg)
    `HSRS_ASSERT_NEXT(a_col_advance, s_accept && !restart && !is_last, col_reg == $past(col_reg) + COL_W'(1))
    `HSRS_ASSERT_NEXT(a_flush_end_restarts, s_accept && flush && is_last, first_row_reg && !flushing_reg && (col_reg == '0))

endmodule

// File: tb/tb_heat_stencil_row_sweep_core.sv
// Self-checking testbench of the heat stencil row sweep core against its own stencil predictor.
module tb_heat_stencil_row_sweep_core;

    localparam int MAX_LEN = hsrs_pkg::MAX_ROW_LENGTH_DEFAULT;
    localparam int FRAC = hsrs_pkg::FRACTION_BITS_DEFAULT;
    localparam logic OP_SAMPLE = 1'b0;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1800;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct packed {
        logic                   op;
        logic [31:0]            temp;
        logic                   typed;
        hsrs_pkg::cell_result_t want;
    } directed_row_t;

    localparam hsrs_pkg::cell_result_t NO_CELL = '0;

    // Three-cell rows at coefficients of one half: extremes, flushing and restarts.
    localparam directed_row_t DIRECTED [20] = '{
        '{OP_SAMPLE,          32'h7FFF_FFFF, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h7FFF_FFFF, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h8000_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
        '{OP_SAMPLE,          32'h8000_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
        '{OP_SAMPLE,          32'h0001_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
        '{OP_SAMPLE,          32'h0000_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'hFFFF_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{hsrs_pkg::OP_FLUSH, 32'h0000_BEEF, 1'b1, '{32'h0001_0000, 1'b0, 1'b0}},
        '{OP_SAMPLE,          32'h1234_5678, 1'b0, NO_CELL},
        '{hsrs_pkg::OP_FLUSH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_0000, 1'b1, 1'b1}},
        '{OP_SAMPLE,          32'h0000_0001, 1'b0, NO_CELL},
        '{hsrs_pkg::OP_FLUSH, 32'h0000_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h0002_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h0003_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h0004_0000, 1'b0, NO_CELL},
        '{OP_SAMPLE,          32'h0005_0000, 1'b1, '{32'h0002_0000, 1'b0, 1'b0}},
        '{hsrs_pkg::OP_FLUSH, 32'h0000_0000, 1'b0, NO_CELL},
        '{hsrs_pkg::OP_FLUSH, 32'h0000_0000, 1'b1, '{32'h0004_0000, 1'b1, 1'b1}}
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [hsrs_pkg::DATA_W-1:0]     s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [hsrs_pkg::DATA_W-1:0]     m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hsrs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hsrs_pkg::CFG_DATA_W-1:0] cfg_data;

    heat_stencil_row_sweep_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the line stores, sequencing and registers.
    logic signed [31:0] upper_row [MAX_LEN];
    logic signed [31:0] middle_row [MAX_LEN];
    int unsigned        col_pos = 0;
    bit                 first_row = 1'b1;
    bit                 upper_valid = 1'b0;
    bit                 draining = 1'b0;
    logic [10:0]        sweep_len = 11'(hsrs_pkg::ROW_LENGTH_RESET);
    logic [15:0]        coef_x_q = '0;
    logic [15:0]        coef_y_q = '0;

    hsrs_pkg::cell_result_t pending_cells [$];
    int           errors = 0;
    int           cells_checked = 0;
    int           cells_offered = 0;
    int           cycle_count = 0;

    // Free-running clock, period of four time units.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int unsigned clamp_len(input logic [10:0] raw);
        if (raw < 11'(hsrs_pkg::MIN_ROW_LENGTH)) return hsrs_pkg::MIN_ROW_LENGTH;
        if (raw > 11'(MAX_LEN)) return MAX_LEN;
        return 32'(raw);
    endfunction

    function automatic void restart_sweep();
        col_pos = 0;
        first_row = 1'b1;
        upper_valid = 1'b0;
        draining = 1'b0;
    endfunction

    // Advances the predictor by one transaction; returns 1 when a cell is emitted.
    function automatic bit diffuse_cell(input logic op, input logic [31:0] temp,
                                        output hsrs_pkg::cell_result_t res);
        int unsigned len;
        int unsigned col;
        bit          flush;
        bit          last;
        bit          emit;
        longint      south;
        longint      centre;
        longint      north;
        longint      west;
        longint      east;
        longint      lap_x;
        longint      lap_y;
        longint      total;
        longint      updated;
        len = clamp_len(sweep_len);
        flush = (op == hsrs_pkg::OP_FLUSH) || draining;
        res = NO_CELL;
        if (flush && first_row) begin
            restart_sweep();
            return 1'b0;
        end
        col = (col_pos >= MAX_LEN) ? MAX_LEN - 1 : col_pos;
        last = col >= len - 1;
        south = flush ? 64'sd0 : longint'($signed(temp));
        centre = longint'(middle_row[col]);
        emit = !first_row;
        updated = centre;
        // Interior cells get the five-point update; edge columns pass through.
        if (emit && col != 0 && !last) begin
            north = upper_valid ? longint'(upper_row[col]) : 64'sd0;
            west = longint'(upper_row[col - 1]);
            east = longint'(middle_row[col + 1]);
            lap_x = west - 2 * centre + east;
            lap_y = north - 2 * centre + south;
            total = longint'(coef_x_q) * lap_x + longint'(coef_y_q) * lap_y;
            updated = centre + ((total + (longint'(1) << (FRAC - 1))) >>> FRAC);
            if (updated > SAT_MAX) updated = SAT_MAX;
            if (updated < SAT_MIN) updated = SAT_MIN;
        end
        upper_row[col] = centre[31:0];
        middle_row[col] = south[31:0];
        res.new_temperature = updated[31:0];
        res.end_of_row = last;
        res.end_of_grid = flush && last;
        if (last) begin
            col_pos = 0;
            if (flush) restart_sweep();
            else if (first_row) first_row = 1'b0;
            else upper_valid = 1'b1;
        end else begin
            col_pos = col + 1;
            if (flush) draining = 1'b1;
        end
        return emit;
    endfunction

    // Idle gaps: mostly none, some short, a few long; quiet stretches have none.
    function automatic int unsigned idle_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_temp();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return (roll < 4) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (roll < 45) return $urandom();
        return 32'($signed($urandom()) >>> $urandom_range(4, 20));
    endfunction

    function automatic logic [15:0] pick_coef();
        int unsigned roll;
        roll = $urandom_range(0, 5);
        if (roll == 0) return 16'd0;
        if (roll == 1) return 16'd32768;
        if (roll == 2) return 16'hFFFF;
        return 16'($urandom_range(0, 32768));
    endfunction

    // Offers one transaction and records what it should produce once accepted.
    task automatic offer_cell(input logic op, input logic [31:0] temp, input logic typed,
                              input hsrs_pkg::cell_result_t typed_res);
        hsrs_pkg::cell_result_t predicted;
        int unsigned            gap;
        gap = idle_gap((cells_offered % 150) < 50);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= temp;
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        cells_offered++;
        if (diffuse_cell(op, temp, predicted))
            pending_cells.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_reg(input hsrs_pkg::cfg_index_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            hsrs_pkg::CFG_ROW_LENGTH: sweep_len = val[10:0];
            hsrs_pkg::CFG_COEF_X:     coef_x_q = val;
            hsrs_pkg::CFG_COEF_Y:     coef_y_q = val;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [15:0] len_val, input logic [15:0] cx_val,
                                  input logic [15:0] cy_val);
        write_reg(hsrs_pkg::CFG_ROW_LENGTH, len_val);
        write_reg(hsrs_pkg::CFG_COEF_X, cx_val);
        write_reg(hsrs_pkg::CFG_COEF_Y, cy_val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every expected cell has come out.
    task automatic drain_results(input int unsigned tail);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // One grid at the current row length: mostly well formed, some broken off.
    task automatic run_grid(input int unsigned len);
        int unsigned shape;
        int unsigned rows;
        int unsigned cut;
        int unsigned n;
        logic        op;
        shape = $urandom_range(0, 99);
        rows = $urandom_range(1, 5);
        // A stray flush while nothing is stored is simply dropped.
        if ($urandom_range(0, 19) == 0)
            offer_cell(hsrs_pkg::OP_FLUSH, random_temp(), 1'b0, NO_CELL);
        if (shape < 8) begin
            // Abandoned while the first row is still open.
            cut = $urandom_range(0, len - 1);
            for (n = 0; n < cut; n++) offer_cell(OP_SAMPLE, random_temp(), 1'b0, NO_CELL);
            offer_cell(hsrs_pkg::OP_FLUSH, random_temp(), 1'b0, NO_CELL);
        end else begin
            cut = (shape < 22) ? $urandom_range(0, len - 1) : 0;
            for (n = 0; n < rows * len + cut; n++)
                offer_cell(OP_SAMPLE, random_temp(), 1'b0, NO_CELL);
            // Flushing runs from the cut column to the end of the row.
            for (n = cut; n < len; n++) begin
                op = (n != cut && $urandom_range(0, 9) == 0) ? OP_SAMPLE : hsrs_pkg::OP_FLUSH;
                offer_cell(op, random_temp(), 1'b0, NO_CELL);
            end
        end
    endtask

    // Stimulus: reset, directed table, then random phases with new settings.
    initial begin : stimulus
        int unsigned phase;
        int unsigned len_val;
        int unsigned eff_len;
        int unsigned n;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = hsrs_pkg::CFG_ROW_LENGTH;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_settings(16'd3, 16'd32768, 16'd32768);
        for (n = 0; n < $size(DIRECTED); n++)
            offer_cell(DIRECTED[n].op, DIRECTED[n].temp, DIRECTED[n].typed, DIRECTED[n].want);

        phase = 0;
        while (cells_offered < ITEM_TARGET) begin
            drain_results(SETTLE_CYCLES);
            n = $urandom_range(0, 99);
            len_val = (n < 75) ? $urandom_range(3, 12) :
                      (n < 95) ? $urandom_range(13, 40) : $urandom_range(41, 200);
            case (phase)
                0:       write_settings(16'(len_val), 16'hFFFF, 16'hFFFF);
                1:       write_settings(16'd2047, pick_coef(), pick_coef());
                2:       write_settings(16'd1024, pick_coef(), pick_coef());
                3, 4, 5: write_settings(16'(phase - 3), pick_coef(), pick_coef());
                default: write_settings(16'(len_val), pick_coef(), pick_coef());
            endcase
            eff_len = clamp_len(sweep_len);
            if (phase == 1) begin
                // Widest row: one full first row, then the first cell of the next row.
                for (n = 0; n <= eff_len; n++)
                    offer_cell(OP_SAMPLE, random_temp(), 1'b0, NO_CELL);
                // A short row length then ends the open row two cells later.
                drain_results(SETTLE_CYCLES);
                write_settings(16'd3, pick_coef(), pick_coef());
                offer_cell(OP_SAMPLE, random_temp(), 1'b0, NO_CELL);
                offer_cell(hsrs_pkg::OP_FLUSH, random_temp(), 1'b0, NO_CELL);
            end else if (phase == 2) begin
                for (n = 0; n < 40; n++)
                    offer_cell(OP_SAMPLE, random_temp(), 1'b0, NO_CELL);
                offer_cell(hsrs_pkg::OP_FLUSH, random_temp(), 1'b0, NO_CELL);
            end else begin
                repeat ($urandom_range(1, 3)) run_grid(eff_len);
            end
            phase++;
        end

        drain_results(TAIL_CYCLES);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, quiet stretches and two long hold-offs.
    initial begin : receiver
        int unsigned stall_left;
        int          holds_done;
        stall_left = 0;
        holds_done = 0;
        m_tready = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ((holds_done == 0 && cells_checked >= 200) ||
                         (holds_done == 1 && cells_checked >= 1200)) begin
                holds_done++;
                stall_left = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = idle_gap(((cycle_count / 128) % 3) == 0);
            end
        end
    end

    // Each result transaction is compared with the oldest expected cell.
    always @(posedge aclk) begin : check_results
        hsrs_pkg::cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h tlast %b tuser %b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                want = pending_cells.pop_front();
                if (m_tdata !== want.new_temperature) begin
                    $display("%0t: new_temperature mismatch: expected %h, actual %h",
                             $time, want.new_temperature, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.end_of_row) begin
                    $display("%0t: end_of_row mismatch: expected %b, actual %b",
                             $time, want.end_of_row, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.end_of_grid) begin
                    $display("%0t: end_of_grid mismatch: expected %b, actual %b",
                             $time, want.end_of_grid, m_tuser);
                    errors++;
                end
                cells_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d cells still expected", $time, pending_cells.size());
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/hsrs_pkg.sv
rtl/core/hsrs_arith.sv
rtl/core/hsrs_fifo.sv
rtl/core/heat_stencil_row_sweep_core.sv
tb/tb_heat_stencil_row_sweep_core.sv
